@@ hw/rtl/gcpe_pkg.sv @@
// shared types and constants for the glyph column pixel expander
// no dependencies; imported by gcpe_ctrl, gcpe_datapath and the top level
package gcpe_pkg;

	// field widths
	localparam int BYTE_W    = 8;
	localparam int COORD_W   = 12;
	localparam int INDEX_W   = 24;
	localparam int COLOR_W   = 16;
	localparam int LW_W      = 13;
	localparam int GDIM_W    = 6;
	localparam int BPC_W     = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// state widths
	localparam int COLBITS_W = 32;
	localparam int BRC_W     = 2;
	localparam int COLCNT_W  = 5;
	localparam int ROW_W     = 5;

	// register limits
	localparam int MAX_LINE_WIDTH       = 4096;
	localparam int MAX_GLYPH_WIDTH      = 32;
	localparam int MAX_GLYPH_HEIGHT     = 32;
	localparam int MAX_BYTES_PER_COLUMN = 4;

	// register reset values
	localparam logic [LW_W-1:0]    LINE_WIDTH_RST  = LW_W'(320);
	localparam logic [GDIM_W-1:0]  GLYPH_WIDTH_RST = GDIM_W'(8);
	localparam logic [GDIM_W-1:0]  GLYPH_HEIGHT_RST = GDIM_W'(8);
	localparam logic [BPC_W-1:0]   BPC_RST         = BPC_W'(1);
	localparam logic [COLOR_W-1:0] FORE_COLOR_RST  = 16'hFFFF;
	localparam logic [COLOR_W-1:0] BACK_COLOR_RST  = 16'h0000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH   = 3'd0,
		REG_GLYPH_WIDTH  = 3'd1,
		REG_GLYPH_HEIGHT = 3'd2,
		REG_BYTES_PER_COL = 3'd3,
		REG_FORE_COLOR   = 3'd4,
		REG_BACK_COLOR   = 3'd5
	} reg_idx_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;     // take the input byte
		logic base_load;  // compute the column's first pixel index
		logic emit_load;  // load the next pixel write into the output register
	} gcpe_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic col_done;   // the byte on the input completes a column
		logic last_row;   // the next pixel write is the bottom of the column
	} gcpe_sts_t;

endpackage

@@ hw/rtl/gcpe_ctrl.sv @@
// controller for the glyph column pixel expander: request sequencing and output valid
// depends on gcpe_pkg
module gcpe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	output logic                pix_valid,
	input  logic                pix_stall,
	input  gcpe_pkg::gcpe_sts_t sts,
	output gcpe_pkg::gcpe_cmd_t cmd
);
	import gcpe_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BASE,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   valid_q;
	logic   out_free;

	// output register can take a new request
	assign out_free = ~valid_q | ~pix_stall;

	// commands
	always_comb begin
		cmd.accept    = (state_q == S_IDLE) & item_valid;
		cmd.base_load = (state_q == S_BASE);
		cmd.emit_load = (state_q == S_EMIT) & out_free;
	end

	assign item_stall = (state_q != S_IDLE);
	assign pix_valid  = valid_q;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (cmd.emit_load) begin
				valid_q <= 1'b1;
			end else if (~pix_stall) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept && sts.col_done) begin
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (cmd.emit_load && sts.last_row) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/gcpe_datapath.sv @@
// datapath for the glyph column pixel expander: config registers, column packing,
// pixel index walk and output register; depends on gcpe_pkg
module gcpe_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [gcpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gcpe_pkg::CFG_DAT_W-1:0]   cfg_wr_data,
	input  logic [gcpe_pkg::BYTE_W-1:0]      glyph_byte,
	input  logic [gcpe_pkg::COORD_W-1:0]     origin_x,
	input  logic [gcpe_pkg::COORD_W-1:0]     origin_y,
	input  gcpe_pkg::gcpe_cmd_t              cmd,
	output gcpe_pkg::gcpe_sts_t              sts,
	output logic [gcpe_pkg::INDEX_W-1:0]     pixel_index,
	output logic [gcpe_pkg::COLOR_W-1:0]     pixel_color,
	output logic                             last_of_column
);
	import gcpe_pkg::*;

	// configuration registers
	logic [LW_W-1:0]    line_width_q;
	logic [GDIM_W-1:0]  glyph_width_q;
	logic [GDIM_W-1:0]  glyph_height_q;
	logic [BPC_W-1:0]   bpc_q;
	logic [COLOR_W-1:0] fore_color_q;
	logic [COLOR_W-1:0] back_color_q;

	// column state
	logic [COLBITS_W-1:0] col_bits_q;
	logic [BRC_W-1:0]     brc_q;
	logic [COLCNT_W-1:0]  col_cnt_q;

	// burst registers
	logic [COORD_W-1:0]   ox_q;
	logic [COORD_W-1:0]   oy_q;
	logic [COLCNT_W-1:0]  base_col_q;
	logic [COLBITS_W-1:0] shift_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [ROW_W-1:0]     row_q;

	// output register
	logic [INDEX_W-1:0]   pix_index_q;
	logic [COLOR_W-1:0]   pix_color_q;
	logic                 pix_last_q;

	// clamped settings
	logic [LW_W-1:0]      stride;
	logic [GDIM_W-1:0]    gw;
	logic [GDIM_W-1:0]    gh;
	logic [BPC_W-1:0]     bpc;

	logic [COLBITS_W-1:0] merged;
	logic [BRC_W-1:0]     brc_next;
	logic [GDIM_W-1:0]    col_inc;
	logic [LW_W+COORD_W-1:0] prod;
	logic [GDIM_W-1:0]    row_inc;

	// clamp settings into range, zero counts as one
	always_comb begin
		if (line_width_q == '0) begin
			stride = LW_W'(1);
		end else if (line_width_q > LW_W'(MAX_LINE_WIDTH)) begin
			stride = LW_W'(MAX_LINE_WIDTH);
		end else begin
			stride = line_width_q;
		end
		if (glyph_width_q == '0) begin
			gw = GDIM_W'(1);
		end else if (glyph_width_q > GDIM_W'(MAX_GLYPH_WIDTH)) begin
			gw = GDIM_W'(MAX_GLYPH_WIDTH);
		end else begin
			gw = glyph_width_q;
		end
		if (glyph_height_q == '0) begin
			gh = GDIM_W'(1);
		end else if (glyph_height_q > GDIM_W'(MAX_GLYPH_HEIGHT)) begin
			gh = GDIM_W'(MAX_GLYPH_HEIGHT);
		end else begin
			gh = glyph_height_q;
		end
		if (bpc_q == '0) begin
			bpc = BPC_W'(1);
		end else if (bpc_q > BPC_W'(MAX_BYTES_PER_COLUMN)) begin
			bpc = BPC_W'(MAX_BYTES_PER_COLUMN);
		end else begin
			bpc = bpc_q;
		end
	end

	// pack the incoming byte, little end first
	always_comb begin
		merged   = col_bits_q | (COLBITS_W'(glyph_byte) << {brc_q, 3'b000});
		brc_next = brc_q + BRC_W'(1);
		col_inc  = GDIM_W'(col_cnt_q) + GDIM_W'(1);
		row_inc  = GDIM_W'(row_q) + GDIM_W'(1);
		prod     = (LW_W+COORD_W)'(oy_q) * (LW_W+COORD_W)'(stride);
	end

	// status
	assign sts.col_done = (brc_next == '0) || (BPC_W'(brc_next) >= bpc);
	assign sts.last_row = (row_inc == gh);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			glyph_width_q  <= GLYPH_WIDTH_RST;
			glyph_height_q <= GLYPH_HEIGHT_RST;
			bpc_q          <= BPC_RST;
			fore_color_q   <= FORE_COLOR_RST;
			back_color_q   <= BACK_COLOR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LINE_WIDTH:    line_width_q   <= cfg_wr_data[LW_W-1:0];
				REG_GLYPH_WIDTH:   glyph_width_q  <= cfg_wr_data[GDIM_W-1:0];
				REG_GLYPH_HEIGHT:  glyph_height_q <= cfg_wr_data[GDIM_W-1:0];
				REG_BYTES_PER_COL: bpc_q          <= cfg_wr_data[BPC_W-1:0];
				REG_FORE_COLOR:    fore_color_q   <= cfg_wr_data[COLOR_W-1:0];
				REG_BACK_COLOR:    back_color_q   <= cfg_wr_data[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// column packing and column counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_bits_q <= '0;
			brc_q      <= '0;
			col_cnt_q  <= '0;
		end else if (cmd.accept) begin
			if (sts.col_done) begin
				col_bits_q <= '0;
				brc_q      <= '0;
				if (col_inc >= gw) begin
					col_cnt_q <= '0;
				end else begin
					col_cnt_q <= col_inc[COLCNT_W-1:0];
				end
			end else begin
				col_bits_q <= merged;
				brc_q      <= brc_next;
			end
		end
	end

	// burst capture, index walk and output register
	always_ff @(posedge clk) begin
		if (cmd.accept && sts.col_done) begin
			shift_q    <= merged;
			ox_q       <= origin_x;
			oy_q       <= origin_y;
			base_col_q <= col_cnt_q;
		end
		if (cmd.base_load) begin
			idx_q <= prod[INDEX_W-1:0] + INDEX_W'(ox_q) + INDEX_W'(base_col_q);
			row_q <= '0;
		end
		if (cmd.emit_load) begin
			pix_index_q <= idx_q;
			pix_color_q <= shift_q[0] ? fore_color_q : back_color_q;
			pix_last_q  <= sts.last_row;
			idx_q       <= idx_q + INDEX_W'(stride);
			shift_q     <= shift_q >> 1;
			row_q       <= row_inc[ROW_W-1:0];
		end
	end

	assign pixel_index    = pix_index_q;
	assign pixel_color    = pix_color_q;
	assign last_of_column = pix_last_q;

endmodule

@@ hw/rtl/glyph_column_pixel_expander_core.sv @@
// Glyph column pixel expander: takes font bytes in column order and writes one
// pixel per cycle, while the output does not stall, down each finished glyph column.
//
// Input channel (item_valid / item_stall): glyph_byte, origin_x, origin_y. One
// font byte per request; bytes_per_column bytes make one column, bit 0 at top.
// Output channel (pix_valid / pix_stall): pixel_index, pixel_color,
// last_of_column, one request per pixel write, glyph_height writes per column.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index
// (0 line_width, 1 glyph_width, 2 glyph_height, 3 bytes_per_column,
// 4 fore_color, 5 back_color); other indexes are ignored.
// Sequence: a byte that does not finish a column is taken with no stall. A byte
// that finishes one is taken, then the base index is formed (origin_y *
// line_width multiply and add), then one pixel write per cycle while the output
// does not stall goes into the output register. The first pixel is valid after
// the S_BASE state and its load in S_EMIT; item_stall stays high until the last
// pixel of the column has been loaded into the output register.
// A stall on the output holds the output register and pauses the column walk.
// Reset (arst_n low) clears the column state and output valid and restores
// the register defaults.
// depends on gcpe_pkg, gcpe_ctrl, gcpe_datapath
module glyph_column_pixel_expander_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [gcpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gcpe_pkg::CFG_DAT_W-1:0]   cfg_wr_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [gcpe_pkg::BYTE_W-1:0]      glyph_byte,
	input  logic [gcpe_pkg::COORD_W-1:0]     origin_x,
	input  logic [gcpe_pkg::COORD_W-1:0]     origin_y,
	output logic                             pix_valid,
	input  logic                             pix_stall,
	output logic [gcpe_pkg::INDEX_W-1:0]     pixel_index,
	output logic [gcpe_pkg::COLOR_W-1:0]     pixel_color,
	output logic                             last_of_column
);
	import gcpe_pkg::*;

	gcpe_cmd_t cmd;
	gcpe_sts_t sts;

	// sequencing
	gcpe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// packing, index arithmetic and output register
	gcpe_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wr_data    (cfg_wr_data),
		.glyph_byte     (glyph_byte),
		.origin_x       (origin_x),
		.origin_y       (origin_y),
		.cmd            (cmd),
		.sts            (sts),
		.pixel_index    (pixel_index),
		.pixel_color    (pixel_color),
		.last_of_column (last_of_column)
	);

endmodule

@@ verif/glyph_column_pixel_expander_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for glyph_column_pixel_expander_core: font bytes and register
// settings go in, every pixel write is predicted and compared on the output channel
// depends on gcpe_pkg and the glyph_column_pixel_expander_core rtl
module glyph_column_pixel_expander_core_tb;
	import gcpe_pkg::*;

	// one pixel write as the block should produce it
	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_write_t;

	// an index that maps to no register, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	// column packer and pixel walker with its own register copy
	class glyph_pixel_scoreboard;
		logic [LW_W-1:0]      line_width;
		logic [GDIM_W-1:0]    glyph_width;
		logic [GDIM_W-1:0]    glyph_height;
		logic [BPC_W-1:0]     bytes_per_col;
		logic [COLOR_W-1:0]   fore_color;
		logic [COLOR_W-1:0]   back_color;
		logic [COLBITS_W-1:0] column_word;
		logic [BRC_W-1:0]     bytes_packed;
		logic [COLCNT_W-1:0]  column_pos;
		pixel_write_t         pending_pixels[$];
		int                   mismatches;
		int                   bytes_taken;
		int                   columns_done;
		int                   pixels_checked;

		function new();
			line_width    = LINE_WIDTH_RST;
			glyph_width   = GLYPH_WIDTH_RST;
			glyph_height  = GLYPH_HEIGHT_RST;
			bytes_per_col = BPC_RST;
			fore_color    = FORE_COLOR_RST;
			back_color    = BACK_COLOR_RST;
			column_word   = '0;
			bytes_packed  = '0;
			column_pos    = '0;
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction

		// zero counts as one, values above range saturate
		function int clamped_width();
			if (glyph_width == 0) return 1;
			if (glyph_width > MAX_GLYPH_WIDTH) return MAX_GLYPH_WIDTH;
			return glyph_width;
		endfunction

		function int clamped_bpc();
			if (bytes_per_col == 0) return 1;
			if (bytes_per_col > MAX_BYTES_PER_COLUMN) return MAX_BYTES_PER_COLUMN;
			return bytes_per_col;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] which, logic [CFG_DAT_W-1:0] value);
			case (which)
				REG_LINE_WIDTH:    line_width    = value[LW_W-1:0];
				REG_GLYPH_WIDTH:   glyph_width   = value[GDIM_W-1:0];
				REG_GLYPH_HEIGHT:  glyph_height  = value[GDIM_W-1:0];
				REG_BYTES_PER_COL: bytes_per_col = value[BPC_W-1:0];
				REG_FORE_COLOR:    fore_color    = value;
				REG_BACK_COLOR:    back_color    = value;
				default: ;
			endcase
		endfunction

		// pack one accepted font byte, queue the column's pixels once it closes
		function void note_request(logic [BYTE_W-1:0] font_byte, logic [COORD_W-1:0] ox,
				logic [COORD_W-1:0] oy);
			longint unsigned stride;
			longint unsigned base;
			int rows;
			int next_col;
			logic [COLBITS_W-1:0] bits;
			pixel_write_t px;
			bytes_taken++;
			column_word = column_word | (COLBITS_W'(font_byte) << (8 * bytes_packed));
			bytes_packed = bytes_packed + 2'd1;
			if (bytes_packed != 0 && bytes_packed < clamped_bpc()) return;

			stride = (line_width == 0) ? 1 :
				(line_width > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : line_width;
			rows = (glyph_height == 0) ? 1 :
				(glyph_height > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : glyph_height;
			base = longint'(oy) * stride + longint'(ox) + longint'(column_pos);
			bits = column_word;
			// walk down the column, bit 0 on top
			for (int r = 0; r < rows; r++) begin
				px.idx   = INDEX_W'(base + longint'(r) * stride);
				px.color = bits[0] ? fore_color : back_color;
				px.last  = (r == rows - 1);
				pending_pixels.push_back(px);
				bits = bits >> 1;
			end

			columns_done++;
			column_word  = '0;
			bytes_packed = '0;
			next_col = column_pos + 1;
			if (next_col >= clamped_width()) next_col = 0;
			column_pos = COLCNT_W'(next_col);
		endfunction

		// compare one accepted pixel write with the oldest expectation
		function void check_pixel(logic [INDEX_W-1:0] got_idx, logic [COLOR_W-1:0] got_color,
				logic got_last);
			pixel_write_t want;
			if (pending_pixels.size() == 0) begin
				$display("%0t unexpected pixel write: index %h color %h last %b",
					$time, got_idx, got_color, got_last);
				mismatches++;
				return;
			end
			want = pending_pixels.pop_front();
			pixels_checked++;
			if (got_idx !== want.idx) begin
				$display("%0t pixel_index expected %h actual %h", $time, want.idx, got_idx);
				mismatches++;
			end
			if (got_color !== want.color) begin
				$display("%0t pixel_color expected %h actual %h (index %h)",
					$time, want.color, got_color, want.idx);
				mismatches++;
			end
			if (got_last !== want.last) begin
				$display("%0t last_of_column expected %b actual %b (index %h)",
					$time, want.last, got_last, want.idx);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wr_data;
	logic                 item_valid;
	logic                 item_stall;
	logic [BYTE_W-1:0]    glyph_byte;
	logic [COORD_W-1:0]   origin_x;
	logic [COORD_W-1:0]   origin_y;
	logic                 pix_valid;
	logic                 pix_stall;
	logic [INDEX_W-1:0]   pixel_index;
	logic [COLOR_W-1:0]   pixel_color;
	logic                 last_of_column;

	glyph_pixel_scoreboard sb;
	bit calm;
	int setups_loaded;

	glyph_column_pixel_expander_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wr_data    (cfg_wr_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.glyph_byte     (glyph_byte),
		.origin_x       (origin_x),
		.origin_y       (origin_y),
		.pix_valid      (pix_valid),
		.pix_stall      (pix_stall),
		.pixel_index    (pixel_index),
		.pixel_color    (pixel_color),
		.last_of_column (last_of_column)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			sb.note_request(glyph_byte, origin_x, origin_y);
		end
		if (arst_n && pix_valid && !pix_stall) begin
			sb.check_pixel(pixel_index, pixel_color, last_of_column);
		end
	end

	// output back-pressure in random bursts, none once calm
	initial begin
		pix_stall = 1'b0;
		forever begin
			repeat ($urandom_range(1, 20)) @(negedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				pix_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				pix_stall <= 1'b0;
			end
		end
	end

	// one register write, block must be idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [CFG_DAT_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= which;
		cfg_wr_data <= value;
		sb.set_reg(which, value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_setup(input logic [CFG_DAT_W-1:0] lw, gw, gh, bpc, fore, back);
		write_reg(REG_LINE_WIDTH, lw);
		write_reg(REG_GLYPH_WIDTH, gw);
		write_reg(REG_GLYPH_HEIGHT, gh);
		write_reg(REG_BYTES_PER_COL, bpc);
		write_reg(REG_FORE_COLOR, fore);
		write_reg(REG_BACK_COLOR, back);
		setups_loaded++;
	endtask

	// one font byte request, with an occasional sender gap first
	task automatic send_byte(input logic [BYTE_W-1:0] font_byte, input logic [COORD_W-1:0] ox,
			input logic [COORD_W-1:0] oy);
		if (!calm && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		item_valid <= 1'b1;
		glyph_byte <= font_byte;
		origin_x   <= ox;
		origin_y   <= oy;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	// hold the sender until every queued pixel write is out
	task automatic wait_drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_setup();
		logic [CFG_DAT_W-1:0] lw;
		logic [CFG_DAT_W-1:0] gw;
		logic [CFG_DAT_W-1:0] gh;
		case ($urandom_range(0, 4))
			0: lw = 16'd0;
			1: lw = 16'd4096;
			2: lw = 16'($urandom);
			default: lw = 16'($urandom_range(1, 4096));
		endcase
		gw = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 63)) : 16'($urandom_range(1, 8));
		gh = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 63)) : 16'($urandom_range(1, 16));
		load_setup(lw, gw, gh, 16'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
	endtask

	// mostly whole glyphs with random content, some loose bytes in between
	task automatic random_phase(input int budget);
		int sent;
		int glyph_bytes;
		logic [COORD_W-1:0] ox;
		logic [COORD_W-1:0] oy;
		sent = 0;
		while (sent < budget) begin
			ox = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom_range(0, 4095));
			oy = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom_range(0, 4095));
			if ($urandom_range(0, 9) < 8) begin
				// a glyph is cut short where the budget runs out
				glyph_bytes = sb.clamped_width() * sb.clamped_bpc();
				if (glyph_bytes > budget - sent) glyph_bytes = budget - sent;
				repeat (glyph_bytes) begin
					send_byte(8'($urandom_range(0, 255)), ox, oy);
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 3)) begin
					send_byte(8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
						12'($urandom_range(0, 4095)));
					sent++;
				end
			end
		end
	endtask

	// main sequence
	initial begin
		sb = new();
		calm = 1'b0;
		setups_loaded = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_LINE_WIDTH;
		cfg_wr_data = '0;
		item_valid = 1'b0;
		glyph_byte = '0;
		origin_x = '0;
		origin_y = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset register values, field extremes
		send_byte(8'hA5, 12'd0, 12'd0);
		send_byte(8'h00, 12'hFFF, 12'hFFF);
		send_byte(8'hFF, 12'd17, 12'd3);
		wait_drain();

		// all registers zero where that means one
		load_setup(16'd0, 16'd0, 16'd0, 16'd0, 16'h1234, 16'hFFFF);
		send_byte(8'h5A, 12'hFFF, 12'd0);
		send_byte(8'h81, 12'd0, 12'hFFF);
		wait_drain();

		// line width, glyph size and bytes per column above range, index wraps past 2^24
		load_setup(16'hFFFF, 16'd63, 16'd63, 16'd7, 16'h0000, 16'h8001);
		send_byte(8'hFF, 12'hFFF, 12'hFFF);
		send_byte(8'h00, 12'hFFF, 12'hFFF);
		send_byte(8'h80, 12'hFFF, 12'hFFF);
		send_byte(8'h01, 12'hFFF, 12'hFFF);
		wait_drain();

		// tall glyph from a single byte, lower rows get back color
		write_reg(REG_BYTES_PER_COL, 16'd1);
		send_byte(8'hC3, 12'd100, 12'd200);
		wait_drain();

		// bytes per column lowered with a column half packed
		write_reg(REG_BYTES_PER_COL, 16'd4);
		send_byte(8'h12, 12'd5, 12'd6);
		send_byte(8'h34, 12'd5, 12'd6);
		wait_drain();
		write_reg(REG_BYTES_PER_COL, 16'd2);
		send_byte(8'h7E, 12'd5, 12'd6);
		wait_drain();

		// column counter left beyond a narrowed glyph width
		write_reg(REG_GLYPH_HEIGHT, 16'd1);
		write_reg(REG_GLYPH_WIDTH, 16'd32);
		write_reg(REG_BYTES_PER_COL, 16'd1);
		repeat (6) send_byte(8'($urandom_range(0, 255)), 12'd40, 12'd9);
		wait_drain();
		write_reg(REG_GLYPH_WIDTH, 16'd2);
		repeat (2) send_byte(8'($urandom_range(0, 255)), 12'd40, 12'd9);
		wait_drain();
		write_reg(REG_SPARE, 16'hFFFF);

		// smallest and largest geometry, then random settings
		load_setup(16'd1, 16'd1, 16'd1, 16'd1, 16'($urandom), 16'($urandom));
		random_phase(60);
		wait_drain();
		load_setup(16'd4096, 16'd32, 16'd32, 16'd4, 16'($urandom), 16'($urandom));
		random_phase(60);
		wait_drain();
		for (int p = 0; p < 5; p++) begin
			random_setup();
			if (p == 4) calm = 1'b1;
			random_phase(60);
			wait_drain();
		end

		repeat (40) @(negedge clk);
		$display("covered %0d font bytes, %0d columns, %0d pixel writes checked",
			sb.bytes_taken, sb.columns_done, sb.pixels_checked);
		$display("across %0d register setups including zero, smallest and saturating values",
			setups_loaded);
		if (sb.pending() != 0) begin
			$display("%0t %0d expected pixel writes never arrived", $time, sb.pending());
		end
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// hard stop if the handshakes hang
	initial begin
		#20_000_000;
		$display("%0t timeout, %0d pixel writes still expected", $time, sb.pending());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
